[hdl/can_signal_extract_scale_macros.svh]
// Assertion macros for the CAN signal extractor checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CAN_SIGNAL_EXTRACT_SCALE_MACROS_SVH
`define CAN_SIGNAL_EXTRACT_SCALE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define CSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cse_pkg.sv]
// Shared types and constants for the CAN signal extractor and scaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package cse_pkg;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Register slot, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_START_POS = 3'd0,
        REG_BIT_LEN   = 3'd1,
        REG_INTEL     = 3'd2,
        REG_SIGNED    = 3'd3,
        REG_FACTOR    = 3'd4,
        REG_OFFSET    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [5:0]         start_position;
        logic [6:0]         bit_length;
        logic               intel_order;
        logic               signed_value;
        logic signed [31:0] scale_factor;
        logic signed [47:0] scale_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_position: 6'd0,
        bit_length:     7'd8,
        intel_order:    1'b1,
        signed_value:   1'b0,
        scale_factor:   32'sd65536,
        scale_offset:   48'sd0
    };

    localparam logic [63:0] SCALED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SCALED_MIN = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

[hdl/cse_regs.sv]
// APB-style configuration register file for the signal extractor.
// Depends on cse_pkg for the register map and the configuration struct.
`default_nettype none

module cse_regs
    import cse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t slot;
    logic     wr_en;

    assign slot   = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Update the addressed register; drop writes beyond the map
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (slot)
                REG_START_POS: cfg_next.start_position = pwdata[5:0];
                REG_BIT_LEN:   cfg_next.bit_length     = pwdata[6:0];
                REG_INTEL:     cfg_next.intel_order    = pwdata[0];
                REG_SIGNED:    cfg_next.signed_value   = pwdata[0];
                REG_FACTOR:    cfg_next.scale_factor   = pwdata[31:0];
                REG_OFFSET:    cfg_next.scale_offset   = pwdata[47:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register, zero extended
    always_comb
    begin
        case (slot)
            REG_START_POS: prdata = {58'd0, cfg_reg.start_position};
            REG_BIT_LEN:   prdata = {57'd0, cfg_reg.bit_length};
            REG_INTEL:     prdata = {63'd0, cfg_reg.intel_order};
            REG_SIGNED:    prdata = {63'd0, cfg_reg.signed_value};
            REG_FACTOR:    prdata = {32'd0, cfg_reg.scale_factor};
            REG_OFFSET:    prdata = {16'd0, cfg_reg.scale_offset};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/cse_extract.sv]
// Two-stage bit field extractor: align by shift, then mask and sign extend.
// Depends on cse_pkg for the configuration struct.
`default_nettype none

module cse_extract
    import cse_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire logic [63:0] payload,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output logic      [63:0] raw
);

    localparam int          PAYLOAD_BITS   = 8 * PAYLOAD_BYTES;
    localparam logic [6:0]  PAYLOAD_BITS_W = 7'(PAYLOAD_BITS);
    localparam logic [63:0] PAYLOAD_MASK   = {64{1'b1}} >> (64 - PAYLOAD_BITS);

    logic [6:0]  first_idx;
    logic [6:0]  avail;
    logic [6:0]  take;
    logic [6:0]  shift_amt;
    logic [63:0] data_in;
    logic [63:0] swapped;
    logic [63:0] src;

    logic        v1_reg;
    logic [63:0] shifted_reg;
    logic [63:0] shifted_next;
    logic        v2_reg;
    logic [63:0] raw_reg;
    logic [63:0] raw_next;
    logic [63:0] masked;
    logic [5:0]  sign_idx;
    logic        sign_on;
    logic        ready1;
    logic        ready2;

    // Field geometry from the static configuration. Motorola order is walked
    // as a linear index over the byte-swapped payload: byte, then bit 7 down.
    always_comb
    begin
        if (cfg.intel_order)
        begin
            first_idx = {1'b0, cfg.start_position};
        end
        else
        begin
            first_idx = {1'b0, cfg.start_position[5:3], ~cfg.start_position[2:0]};
        end
        avail = (first_idx < PAYLOAD_BITS_W) ? (PAYLOAD_BITS_W - first_idx) : 7'd0;
        take  = (cfg.bit_length < avail) ? cfg.bit_length : avail;
        if (cfg.intel_order)
        begin
            shift_amt = first_idx;
        end
        else
        begin
            shift_amt = 7'd64 - first_idx - take;
        end
    end

    // Stage 1: drop bytes past the payload and right-align the field
    always_comb
    begin
        data_in = payload & PAYLOAD_MASK;
        for (int k = 0; k < 8; k++)
        begin
            swapped[8*k +: 8] = data_in[8*(7-k) +: 8];
        end
        src          = cfg.intel_order ? data_in : swapped;
        shifted_next = src >> shift_amt;
    end

    // Stage 2: keep the bits that were walked, then sign extend
    always_comb
    begin
        masked   = shifted_reg & ({64{1'b1}} >> (7'd64 - take));
        sign_idx = cfg.bit_length[5:0] - 6'd1;
        sign_on  = cfg.signed_value && (cfg.bit_length != 7'd0) &&
                   (cfg.bit_length < 7'd64) && masked[sign_idx];
        raw_next = sign_on ? (masked | ({64{1'b1}} << cfg.bit_length[5:0])) : masked;
    end

    // Advance a stage when it is empty or the next one takes its item
    assign ready2   = !v2_reg || dn_ready;
    assign ready1   = !v1_reg || ready2;
    assign up_ready = ready1;
    assign dn_valid = v2_reg;
    assign raw      = raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= up_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && up_valid)
        begin
            shifted_reg <= shifted_next;
        end
        if (ready2 && v1_reg)
        begin
            raw_reg <= raw_next;
        end
    end

endmodule

`default_nettype wire

[hdl/cse_scale.sv]
// Three-stage fixed-point scaler: partial products, product sum, offset and
// saturation. Depends on cse_pkg for the configuration struct and limits.
`default_nettype none

module cse_scale
    import cse_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire logic        [63:0] raw_in,
    output logic                    dn_valid,
    input  wire logic               dn_ready,
    output logic signed      [63:0] raw_value,
    output logic signed      [63:0] scaled_value,
    output logic                    saturated
);

    logic               v3_reg;
    logic               v4_reg;
    logic               v5_reg;
    logic signed [64:0] pp_lo_reg;
    logic signed [64:0] pp_lo_next;
    logic signed [63:0] pp_hi_reg;
    logic signed [63:0] pp_hi_next;
    logic        [63:0] raw3_reg;
    logic        [63:0] raw4_reg;
    logic        [63:0] raw5_reg;
    logic        [95:0] prod_reg;
    logic        [95:0] prod_next;
    logic        [96:0] sum;
    logic               sat_next;
    logic        [63:0] scaled_next;
    logic        [63:0] scaled_reg;
    logic               sat_reg;
    logic               ready3;
    logic               ready4;
    logic               ready5;

    // Stage 3: two 32-bit slices of the raw value times the factor
    assign pp_lo_next = $signed({1'b0, raw_in[31:0]}) * cfg.scale_factor;
    assign pp_hi_next = $signed(raw_in[63:32]) * cfg.scale_factor;

    // Stage 4: recombine the slices into the full 96-bit product
    assign prod_next = {pp_hi_reg, 32'd0} + {{31{pp_lo_reg[64]}}, pp_lo_reg};

    // Stage 5: add the offset and clip to the signed 64-bit range
    always_comb
    begin
        sum         = {prod_reg[95], prod_reg} + {{49{cfg.scale_offset[47]}}, cfg.scale_offset};
        sat_next    = (sum[96:63] != {34{sum[96]}});
        scaled_next = sat_next ? (sum[96] ? SCALED_MIN : SCALED_MAX) : sum[63:0];
    end

    assign ready5   = !v5_reg || dn_ready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign up_ready = ready3;

    assign dn_valid     = v5_reg;
    assign raw_value    = raw5_reg;
    assign scaled_value = scaled_reg;
    assign saturated    = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready3)
            begin
                v3_reg <= up_valid;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && up_valid)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            raw3_reg  <= raw_in;
        end
        if (ready4 && v3_reg)
        begin
            prod_reg <= prod_next;
            raw4_reg <= raw3_reg;
        end
        if (ready5 && v4_reg)
        begin
            scaled_reg <= scaled_next;
            sat_reg    <= sat_next;
            raw5_reg   <= raw4_reg;
        end
    end

endmodule

`default_nettype wire

[hdl/can_signal_extract_scale.sv]
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   payload[63:0]
// output    out        out_valid / out_stall raw_value, scaled_value, saturated
// config    in         APB psel/penable      paddr[5:0] at 8*index, pwdata[63:0]
//
// One frame per cycle while in_stall is low; each frame passes through the five
// register stages in order: align, mask and sign, partial products, product sum,
// offset add with saturation.
// Reset clears the stage valid bits and loads register defaults; no clearing pass.
// out_stall holds the output register only; empty stages behind it keep
// filling, and in_stall rises only when all five stages hold a transaction.
//
// Top level of the CAN signal extractor and scaler.
// Depends on cse_pkg, cse_regs, cse_extract and cse_scale.
`default_nettype none

module can_signal_extract_scale
    import cse_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [63:0]           payload,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [63:0]         raw_value,
    output logic signed [63:0]         scaled_value,
    output logic                       saturated
);

    cfg_t        cfg;
    logic        in_ready;
    logic        mid_valid;
    logic        mid_ready;
    logic [63:0] mid_raw;

    cse_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cse_extract #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_extract (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .payload  (payload),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .raw      (mid_raw)
    );

    cse_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .up_valid     (mid_valid),
        .up_ready     (mid_ready),
        .raw_in       (mid_raw),
        .dn_valid     (out_valid),
        .dn_ready     (!out_stall),
        .raw_value    (raw_value),
        .scaled_value (scaled_value),
        .saturated    (saturated)
    );

    assign in_stall = !in_ready;

endmodule

`default_nettype wire

[hdl/cse_checker.sv]
// Port-level assertions for the CAN signal extractor, bound to the top level.
// Depends on cse_pkg and can_signal_extract_scale_macros.svh.
`default_nettype none
`include "can_signal_extract_scale_macros.svh"

module cse_checker
    import cse_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] raw_value,
    input wire logic [63:0] scaled_value,
    input wire logic        saturated
);

    // A stalled result holds its transaction
    `CSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(raw_value) && $stable(scaled_value) && $stable(saturated), "stalled result changed")

    // Input back-pressure only when the output side is full and stalled
    `CSE_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while output side free")

    // A clipped result sits at one of the two limits
    `CSE_ASSERT_SAME(a_sat_limit, clk, rst_n, out_valid && saturated, scaled_value == SCALED_MAX || scaled_value == SCALED_MIN, "saturated result not at a limit")

    // With no output stall a transaction emerges after five stages
    `CSE_ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "transaction lost in pipeline")

endmodule

bind can_signal_extract_scale cse_checker u_cse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raw_value    (raw_value),
    .scaled_value (scaled_value),
    .saturated    (saturated)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for can_signal_extract_scale: directed and random frames are
// compared with a bit-accurate extract-and-scale predictor under random stalls.
// Depends on cse_pkg and the can_signal_extract_scale RTL.

import cse_pkg::*;

typedef struct packed {
    logic signed [63:0] raw;
    logic signed [63:0] scaled;
    logic               sat;
} signal_result_t;

// Predicts the decoded signal of each accepted frame and checks the results in order
class signal_tracker;
    localparam int          FRAME_BYTES = 8;
    localparam int          REPORT_LIMIT = 10;
    localparam logic [63:0] CLIP_HIGH = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CLIP_LOW  = 64'h8000_0000_0000_0000;

    cfg_t           regs;
    signal_result_t awaited_results[$];
    int             errors;

    function new();
        regs.start_position = 6'd0;
        regs.bit_length     = 7'd8;
        regs.intel_order    = 1'b1;
        regs.signed_value   = 1'b0;
        regs.scale_factor   = 32'sd65536;
        regs.scale_offset   = 48'sd0;
        errors = 0;
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Mirror a register write; spare slots are ignored
    function void set_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            REG_START_POS: regs.start_position = value[5:0];
            REG_BIT_LEN:   regs.bit_length     = value[6:0];
            REG_INTEL:     regs.intel_order    = value[0];
            REG_SIGNED:    regs.signed_value   = value[0];
            REG_FACTOR:    regs.scale_factor   = value[31:0];
            REG_OFFSET:    regs.scale_offset   = value[47:0];
            default:       ;
        endcase
    endfunction

    // Walk the payload in Intel or Motorola order, then sign-extend if asked
    function logic [63:0] extract_signal(logic [63:0] data);
        logic [63:0] acc;
        int          pos;
        acc = '0;
        if (regs.intel_order)
        begin
            for (int i = 0; i < int'(regs.bit_length); i++)
            begin
                pos = int'(regs.start_position) + i;
                if (pos >= 8 * FRAME_BYTES)
                    break;
                acc[i] = data[pos];
            end
        end
        else
        begin
            pos = int'(regs.start_position);
            for (int i = 0; i < int'(regs.bit_length); i++)
            begin
                if (pos >= 8 * FRAME_BYTES)
                    break;
                acc = {acc[62:0], data[pos]};
                pos = (pos % 8 == 0) ? pos + 15 : pos - 1;
            end
        end
        if (regs.signed_value && regs.bit_length > 7'd0 && regs.bit_length < 7'd64)
        begin
            if (acc[regs.bit_length - 7'd1])
                acc = acc | ({64{1'b1}} << regs.bit_length);
        end
        return acc;
    endfunction

    // Exact raw*factor+offset in 128 bits, clipped to the signed 64-bit range
    function signal_result_t scale_signal(logic signed [63:0] raw);
        signal_result_t      res;
        logic signed [127:0] exact;
        exact = $signed(raw) * $signed(regs.scale_factor) + $signed(regs.scale_offset);
        res.raw = raw;
        if (exact[127:63] == {65{1'b0}} || exact[127:63] == {65{1'b1}})
        begin
            res.scaled = exact[63:0];
            res.sat    = 1'b0;
        end
        else
        begin
            res.scaled = exact[127] ? CLIP_LOW : CLIP_HIGH;
            res.sat    = 1'b1;
        end
        return res;
    endfunction

    function void note_frame(logic [63:0] data);
        awaited_results.insert(awaited_results.size(), scale_signal(extract_signal(data)));
    endfunction

    function void check_result(logic signed [63:0] raw, logic signed [63:0] scaled,
                               logic sat);
        signal_result_t want;
        if (awaited_results.size() == 0)
        begin
            note_error($sformatf("unexpected transaction raw %h scaled %h sat %b",
                                 raw, scaled, sat));
            return;
        end
        want = awaited_results.pop_front();
        if (raw !== want.raw || scaled !== want.scaled || sat !== want.sat)
            note_error($sformatf("raw exp %h got %h, scaled exp %h got %h, sat exp %b got %b",
                                 want.raw, raw, want.scaled, scaled, want.sat, sat));
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    // Count results that never came back
    function void close();
        if (awaited_results.size() != 0)
        begin
            note_error($sformatf("%0d expected transactions never arrived",
                                 awaited_results.size()));
            errors += awaited_results.size() - 1;
        end
    endfunction
endclass

module tb_top;
    localparam int         HALF_PERIOD_NS = 6;
    localparam int         RESET_CYCLES   = 4;
    localparam int         RANDOM_FRAMES  = 800;
    localparam int         MAX_GAP        = 13;
    localparam int         DRAIN_LIMIT    = 4000;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         RUN_LIMIT_NS   = 6_000_000;
    localparam logic [2:0] REG_SPARE_LO   = 3'd6;
    localparam logic [2:0] REG_SPARE_HI   = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [63:0]           payload;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [63:0]    raw_value;
    logic signed [63:0]    scaled_value;
    logic                  saturated;

    bit                    calm;
    signal_tracker         tracker;

    can_signal_extract_scale #(.PAYLOAD_BYTES(8)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .raw_value    (raw_value),
        .scaled_value (scaled_value),
        .saturated    (saturated)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD_NS);
        clk = 1'b1;
        #(HALF_PERIOD_NS);
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL can_signal_extract_scale");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [63:0] random_payload();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic cfg_t make_cfg(input logic [5:0] start, input logic [6:0] len,
                                      input logic intel, input logic sgn,
                                      input logic [31:0] factor, input logic [47:0] offset);
        cfg_t c;
        c.start_position = start;
        c.bit_length     = len;
        c.intel_order    = intel;
        c.signed_value   = sgn;
        c.scale_factor   = factor;
        c.scale_offset   = offset;
        return c;
    endfunction

    // One APB write: setup then access; psel stays up for back-to-back writes
    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_reg(idx, value);
    endtask

    // Program every register, optionally poke the unused slots, then release the bus
    task automatic load_config(input cfg_t c, input bit poke_spare);
        apb_write(REG_START_POS, {58'd0, c.start_position});
        apb_write(REG_BIT_LEN,   {57'd0, c.bit_length});
        apb_write(REG_INTEL,     {63'd0, c.intel_order});
        apb_write(REG_SIGNED,    {63'd0, c.signed_value});
        apb_write(REG_FACTOR,    {32'd0, c.scale_factor});
        apb_write(REG_OFFSET,    {16'd0, c.scale_offset});
        if (poke_spare)
        begin
            apb_write(REG_SPARE_LO, {$urandom, $urandom});
            apb_write(REG_SPARE_HI, '1);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one frame after a random gap and hold it until accepted
    task automatic send_frame(input logic [63:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        payload  <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_frame(data);
    endtask

    // Drop valid and wait until every outstanding transaction has returned
    task automatic close_phase();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output side: stall for a random count per transaction, then accept
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Check each accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(raw_value, scaled_value, saturated);
    end

    initial
    begin
        int          sent;
        int          n;
        logic [6:0]  len;
        logic [31:0] factor;
        logic [47:0] offset;

        tracker  = new();
        calm     = 1'b0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        payload  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset layout: byte 0, Intel, unity factor
        send_frame('0);
        send_frame('1);
        send_frame(64'h0123_4567_89AB_CDEF);
        close_phase();

        // Intel signal running past the payload end; spare slots must be ignored
        load_config(make_cfg(6'd60, 7'd8, 1'b1, 1'b0, 32'h0001_0000, 48'd0), 1'b1);
        send_frame('1);
        send_frame(64'hA5C3_0F96_5A3C_F069);
        close_phase();

        // Motorola full sawtooth walk of 64 bits
        load_config(make_cfg(6'd7, 7'd64, 1'b0, 1'b0, 32'h0001_0000, 48'd0), 1'b0);
        send_frame(random_payload());
        send_frame(64'h8000_0000_0000_0001);
        close_phase();

        // Motorola walk cut short at the payload end, signed
        load_config(make_cfg(6'd60, 7'd16, 1'b0, 1'b1, 32'h0001_0000, 48'd0), 1'b0);
        send_frame('1);
        send_frame(64'h1000_0000_0000_0000);
        close_phase();

        // Short Motorola walk with its sign bit set
        load_config(make_cfg(6'd62, 7'd3, 1'b0, 1'b1, 32'hFFFF_0000, 48'd0), 1'b0);
        send_frame('1);
        close_phase();

        // Zero length: scaled result is the offset alone
        load_config(make_cfg(6'd5, 7'd0, 1'b1, 1'b1, 32'h0001_0000, 48'h7FFF_FFFF_FFFF), 1'b0);
        send_frame('1);
        close_phase();

        // Full-width raw with largest factor and offset: both clip directions
        load_config(make_cfg(6'd0, 7'd64, 1'b1, 1'b1, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF), 1'b0);
        send_frame(64'h7FFF_FFFF_FFFF_FFFF);
        send_frame(64'h8000_0000_0000_0000);
        send_frame('1);
        send_frame('0);
        close_phase();

        // Most negative factor and offset
        load_config(make_cfg(6'd0, 7'd64, 1'b1, 1'b0, 32'h8000_0000, 48'h8000_0000_0000), 1'b0);
        send_frame(64'h8000_0000_0000_0000);
        send_frame(64'h7FFF_FFFF_FFFF_FFFF);
        send_frame(64'd1);
        close_phase();

        // One signed bit at the top of the frame, negative factor
        load_config(make_cfg(6'd63, 7'd1, 1'b1, 1'b1, 32'hFFFD_0000, 48'h8000_0000_0000), 1'b0);
        send_frame(64'h8000_0000_0000_0000);
        send_frame('0);
        close_phase();

        // Length beyond 64 in Motorola order
        load_config(make_cfg(6'd0, 7'd127, 1'b0, 1'b1, 32'h0000_8000, 48'h0000_0001_0000), 1'b0);
        send_frame(random_payload());
        close_phase();

        // Random layouts, scaling and frames, phase by phase
        sent = 0;
        while (sent < RANDOM_FRAMES)
        begin
            case ($urandom_range(0, 9))
                0:       len = 7'd0;
                1:       len = 7'd64;
                2:       len = 7'($urandom_range(65, 127));
                3:       len = 7'd1;
                default: len = 7'($urandom_range(1, 63));
            endcase
            case ($urandom_range(0, 5))
                0:       factor = 32'h7FFF_FFFF;
                1:       factor = 32'h8000_0000;
                2:       factor = 32'h0001_0000;
                3:       factor = 32'($urandom_range(0, 1048576)) - 32'd524288;
                default: factor = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       offset = 48'd0;
                1:       offset = 48'h7FFF_FFFF_FFFF;
                2:       offset = 48'h8000_0000_0000;
                default: offset = 48'({$urandom, $urandom});
            endcase
            load_config(make_cfg(6'($urandom_range(0, 63)), len, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), factor, offset),
                        $urandom_range(0, 5) == 0);
            calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(8, 60);
            repeat (n) send_frame(random_payload());
            sent += n;
            close_phase();
        end

        tracker.close();
        if (tracker.errors == 0)
            $display("PASS can_signal_extract_scale");
        else
            $display("FAIL can_signal_extract_scale");
        $finish;
    end
endmodule
